@@ rtl/tabular_q_learning_agent_unit_assert.svh @@
// Assertion macros for the agent's back end.
// Both macros sample on aclk and are switched off while aresetn is low.
`ifndef TABULAR_Q_LEARNING_AGENT_UNIT_ASSERT_SVH
`define TABULAR_Q_LEARNING_AGENT_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define TQLA_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define TQLA_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/tqla_pkg.sv @@
package tqla_pkg;

    localparam int STATE_W     = 8;
    localparam int ACT_W       = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_LEARN_RATE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DISCOUNT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPLORE      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRUIT_REWARD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRASH_REWARD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOVE_REWARD  = 3'd5;

    localparam logic [CFG_W-1:0] RST_LEARN_RATE   = 16'd3277;
    localparam logic [CFG_W-1:0] RST_DISCOUNT     = 16'd58982;
    localparam logic [CFG_W-1:0] RST_EXPLORE      = 16'd19661;
    localparam logic [CFG_W-1:0] RST_FRUIT_REWARD = 16'd1000;
    localparam logic [CFG_W-1:0] RST_CRASH_REWARD = 16'hFC18;
    localparam logic [CFG_W-1:0] RST_MOVE_REWARD  = 16'd1;

    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_LEARN  = 1'b1;

    localparam logic [1:0] OUTCOME_MOVE  = 2'd0;
    localparam logic [1:0] OUTCOME_FRUIT = 2'd1;
    localparam logic [1:0] OUTCOME_CRASH = 2'd2;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic                     op;
        logic [STATE_W-1:0]       next_state;
        logic                     crash;
        logic signed [CFG_W-1:0]  reward;
        logic                     explore;
        logic [ACT_W-1:0]         rand_action;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] learn_rate;
        logic [CFG_W-1:0] discount;
    } coef_t;

endpackage

@@ rtl/tqla_front.sv @@
module tqla_front #(
    parameter int NUM_STATES  = 16,
    parameter int NUM_ACTIONS = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tqla_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tqla_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,
    input  logic                                s_tuser,
    input  logic                                queue_full,
    output logic                                push,
    output tqla_pkg::item_t                     push_item,
    output tqla_pkg::coef_t                     coef
);

    localparam int SWF = tqla_pkg::STATE_W;
    localparam int AWF = tqla_pkg::ACT_W;

    logic [tqla_pkg::CFG_W-1:0] learn_rate_reg;
    logic [tqla_pkg::CFG_W-1:0] discount_reg;
    logic [tqla_pkg::CFG_W-1:0] explore_reg;
    logic [tqla_pkg::CFG_W-1:0] fruit_reg;
    logic [tqla_pkg::CFG_W-1:0] crash_reg;
    logic [tqla_pkg::CFG_W-1:0] move_reg;

    logic [3:0]  in_state;
    logic [1:0]  in_outcome;
    logic [15:0] in_draw;
    logic [1:0]  in_rand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg <= tqla_pkg::RST_LEARN_RATE;
            discount_reg   <= tqla_pkg::RST_DISCOUNT;
            explore_reg    <= tqla_pkg::RST_EXPLORE;
            fruit_reg      <= tqla_pkg::RST_FRUIT_REWARD;
            crash_reg      <= tqla_pkg::RST_CRASH_REWARD;
            move_reg       <= tqla_pkg::RST_MOVE_REWARD;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tqla_pkg::CFG_LEARN_RATE:   learn_rate_reg <= cfg_wdata;
                tqla_pkg::CFG_DISCOUNT:     discount_reg   <= cfg_wdata;
                tqla_pkg::CFG_EXPLORE:      explore_reg    <= cfg_wdata;
                tqla_pkg::CFG_FRUIT_REWARD: fruit_reg      <= cfg_wdata;
                tqla_pkg::CFG_CRASH_REWARD: crash_reg      <= cfg_wdata;
                tqla_pkg::CFG_MOVE_REWARD:  move_reg       <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign in_state   = s_tdata[3:0];
    assign in_outcome = s_tdata[5:4];
    assign in_draw    = s_tdata[21:6];
    assign in_rand    = s_tdata[23:22];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_item.op         = s_tuser;
        push_item.next_state = (32'(in_state) >= NUM_STATES) ? SWF'(NUM_STATES - 1)
                                                             : SWF'(in_state);
        push_item.crash      = (in_outcome == tqla_pkg::OUTCOME_CRASH);
        push_item.explore    = (in_draw < explore_reg);
        push_item.rand_action = (32'(in_rand) >= NUM_ACTIONS) ? AWF'(NUM_ACTIONS - 1)
                                                              : AWF'(in_rand);
        unique case (in_outcome)
            tqla_pkg::OUTCOME_FRUIT: push_item.reward = fruit_reg;
            tqla_pkg::OUTCOME_CRASH: push_item.reward = crash_reg;
            default:                 push_item.reward = move_reg;
        endcase
    end

    assign coef.learn_rate = learn_rate_reg;
    assign coef.discount   = discount_reg;

endmodule

@@ rtl/tqla_fifo.sv @@
module tqla_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  tqla_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output tqla_pkg::item_t rd_item,
    output logic            empty
);

    localparam int DEPTH = tqla_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    tqla_pkg::item_t entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/tqla_back.sv @@
module tqla_back #(
    parameter int NUM_STATES  = 16,
    parameter int NUM_ACTIONS = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  tqla_pkg::coef_t coef,
    input  logic            queue_empty,
    input  tqla_pkg::item_t queue_head,
    output logic            queue_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,
    output logic            m_tuser
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int AW    = $clog2(NUM_ACTIONS);
    localparam int ROW_W = NUM_ACTIONS * 32;
    localparam logic [ROW_W-1:0] ONE_ROW = {NUM_ACTIONS{tqla_pkg::ONE_Q16}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    tqla_pkg::item_t       item_reg;
    logic [SW-1:0]         cur_state_reg;
    logic [AW-1:0]         last_act_reg;

    logic [ROW_W-1:0]      mem [NUM_STATES];
    logic [NUM_STATES-1:0] row_valid_reg;
    logic [ROW_W-1:0]      rd_a_reg;
    logic [ROW_W-1:0]      rd_b_reg;
    logic                  va_reg;
    logic                  vb_reg;
    logic [SW-1:0]         head_state;

    logic [ROW_W-1:0]      row_a_eff;
    logic [ROW_W-1:0]      row_b_eff;
    logic [ROW_W-1:0]      row_a_reg;
    logic [ROW_W-1:0]      scan_row_reg;
    logic signed [31:0]    q_reg;
    logic signed [31:0]    best_reg;
    logic [AW-1:0]         best_idx_reg;
    logic [AW-1:0]         cnt_reg;
    logic signed [31:0]    scan_entry;
    logic                  scan_last;

    logic signed [48:0]    prod1_reg;
    logic signed [48:0]    rnd1_sum;
    logic signed [32:0]    rnd1;
    logic signed [31:0]    reward_q;
    logic signed [33:0]    target;
    logic signed [34:0]    diff_reg;
    logic signed [51:0]    prod2_reg;
    logic signed [51:0]    rnd2_sum;
    logic signed [35:0]    rnd2;
    logic signed [36:0]    nv_wide;
    logic [31:0]           nv;

    logic                  is_learn;
    logic                  out_free;
    logic                  mem_we;
    logic [ROW_W-1:0]      row_wr;
    logic [AW-1:0]         act;

    assign is_learn   = (item_reg.op == tqla_pkg::OP_LEARN);
    assign out_free   = !m_tvalid || m_tready;
    assign queue_pop  = (state_reg == ST_IDLE) && !queue_empty;
    assign head_state = queue_head.next_state[SW-1:0];
    assign mem_we     = (state_reg == ST_DONE) && out_free && is_learn;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cur_state_reg] <= row_wr;
        end
        rd_a_reg <= mem[cur_state_reg];
        rd_b_reg <= mem[head_state];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (mem_we) begin
            row_valid_reg[cur_state_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        va_reg <= row_valid_reg[cur_state_reg];
        vb_reg <= row_valid_reg[head_state];
    end

    assign row_a_eff  = va_reg ? rd_a_reg : ONE_ROW;
    assign row_b_eff  = vb_reg ? rd_b_reg : ONE_ROW;
    assign scan_entry = scan_row_reg[32 * cnt_reg +: 32];
    assign scan_last  = (cnt_reg == AW'(NUM_ACTIONS - 1));

    assign rnd1_sum = prod1_reg + 49'sd32768;
    assign rnd1     = rnd1_sum[48:16];
    assign reward_q = {item_reg.reward, 16'h0000};
    assign target   = 34'(reward_q) + 34'(rnd1);

    assign rnd2_sum = prod2_reg + 52'sd32768;
    assign rnd2     = rnd2_sum[51:16];
    assign nv_wide  = 37'(q_reg) + 37'(rnd2);

    always_comb begin
        if (nv_wide[36:31] == 6'b000000 || nv_wide[36:31] == 6'b111111) begin
            nv = nv_wide[31:0];
        end else if (nv_wide[36]) begin
            nv = 32'h8000_0000;
        end else begin
            nv = 32'h7FFF_FFFF;
        end
    end

    always_comb begin
        row_wr = row_a_reg;
        row_wr[32 * last_act_reg +: 32] = nv;
    end

    assign act = item_reg.explore ? AW'(item_reg.rand_action) : best_idx_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = is_learn ? ST_MUL1 : ST_DONE;
                end
            end
            ST_MUL1: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_state_reg <= '0;
            last_act_reg  <= '0;
            m_tvalid      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid <= 1'b1;
                if (is_learn) begin
                    if (!item_reg.crash) begin
                        cur_state_reg <= item_reg.next_state[SW-1:0];
                    end
                end else begin
                    last_act_reg <= act;
                end
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    item_reg <= queue_head;
                end
            end
            ST_LOAD: begin
                row_a_reg    <= row_a_eff;
                scan_row_reg <= is_learn ? row_b_eff : row_a_eff;
                q_reg        <= row_a_eff[32 * last_act_reg +: 32];
                best_reg     <= is_learn ? row_b_eff[31:0] : row_a_eff[31:0];
                best_idx_reg <= '0;
                cnt_reg      <= AW'(1);
            end
            ST_SCAN: begin
                if (scan_entry > best_reg) begin
                    best_reg     <= scan_entry;
                    best_idx_reg <= cnt_reg;
                end
                if (!scan_last) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_MUL1: prod1_reg <= $signed({1'b0, coef.discount}) * best_reg;
            ST_DIFF: diff_reg  <= 35'(target) - 35'(q_reg);
            ST_MUL2: prod2_reg <= $signed({1'b0, coef.learn_rate}) * diff_reg;
            ST_DONE: begin
                if (out_free) begin
                    if (is_learn) begin
                        m_tdata <= {6'b000000, nv, 2'(last_act_reg)};
                        m_tuser <= 1'b0;
                    end else begin
                        m_tdata <= {6'b000000, 32'h0000_0000, 2'(act)};
                        m_tuser <= item_reg.explore;
                    end
                end
            end
            default: begin
            end
        endcase
    end

`include "tabular_q_learning_agent_unit_assert.svh"

    `TQLA_ASSERT_NOW(a_result_from_done, $rose(m_tvalid), $past(state_reg) == ST_DONE, "result word raised outside the final step")
    `TQLA_ASSERT_NOW(a_state_in_range, 1'b1, 32'(cur_state_reg) < NUM_STATES, "current state points outside the table")
    `TQLA_ASSERT_NEXT(a_done_hands_off, (state_reg == ST_DONE) && out_free, (state_reg == ST_IDLE) && m_tvalid, "final step did not hand off its result")

endmodule

@@ rtl/tabular_q_learning_agent_unit.sv @@
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata, s_tuser
// m_        out        m_tvalid / m_tready  m_tdata, m_tuser
// cfg_      in         cfg_we               cfg_addr, cfg_wdata
//
// A choose word passes through the back end's load, scan and final steps, and a learn
// word also through the two multiply stages with a difference step between them; the
// scan covers one table row, one entry per cycle.
// Table rows read as 1.0 until first written, tracked by a valid flag per row
// that reset clears, so no clearing pass follows reset.
// Incoming words wait in a two-entry queue while the back end works; a result held in
// the output register stalls the back end, and once the queue is full also the input.
module tabular_q_learning_agent_unit #(
    parameter int NUM_STATES  = 16,
    parameter int NUM_ACTIONS = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tqla_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tqla_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // next_state[3:0], outcome[5:4], explore_draw[21:6], random_action[23:22]
    input  logic [23:0]                     s_tdata,
    // op
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // action[1:0], new_value[33:2], zero fill[39:34]
    output logic [39:0]                     m_tdata,
    // explored
    output logic                            m_tuser
);

    logic            push;
    tqla_pkg::item_t push_item;
    logic            queue_full;
    logic            queue_pop;
    tqla_pkg::item_t queue_head;
    logic            queue_empty;
    tqla_pkg::coef_t coef;

    tqla_front #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item),
        .coef       (coef)
    );

    tqla_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_item (push_item),
        .full    (queue_full),
        .rd_en   (queue_pop),
        .rd_item (queue_head),
        .empty   (queue_empty)
    );

    tqla_back #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .coef        (coef),
        .queue_empty (queue_empty),
        .queue_head  (queue_head),
        .queue_pop   (queue_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

@@ sim/tabular_q_learning_agent_unit_tb.sv @@
module tabular_q_learning_agent_unit_tb;

    localparam int STATES     = 16;
    localparam int ACTIONS    = 3;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 16;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct packed {
        logic       op;
        logic [3:0] next_state;
        logic [1:0] outcome;
        logic [15:0] draw;
        logic [1:0] rnd_action;
    } agent_word_t;

    typedef struct packed {
        logic [1:0]         action;
        logic               explored;
        logic signed [31:0] new_value;
    } agent_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [tqla_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [tqla_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    tabular_q_learning_agent_unit #(
        .NUM_STATES (STATES),
        .NUM_ACTIONS(ACTIONS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the agent's table, position and settings.
    logic signed [31:0] q_table [STATES*ACTIONS];
    int unsigned        cur_state;
    int unsigned        prev_action;
    int                 alpha_q16;
    int                 gamma_q16;
    int                 epsilon_q16;
    int                 fruit_pts;
    int                 crash_pts;
    int                 move_pts;

    agent_word_t   pending_words[$];
    agent_result_t expected_results[$];
    int            mismatch_count = 0;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            sender_pause;
    bit            long_hold;
    int            hold_cycles;
    int            cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic int unsigned row_best(int unsigned s, output logic signed [31:0] top);
        int unsigned pick;
        pick = 0;
        top  = q_table[s*ACTIONS];
        for (int unsigned a = 1; a < ACTIONS; a++) begin
            if (q_table[s*ACTIONS + a] > top) begin
                top  = q_table[s*ACTIONS + a];
                pick = a;
            end
        end
        return pick;
    endfunction

    function automatic agent_result_t predict_agent_step(agent_word_t w);
        agent_result_t      r;
        int unsigned        nxt;
        int unsigned        act;
        int unsigned        idx;
        logic signed [31:0] top;
        longint             reward;
        longint             target;
        longint             q;
        longint             nv;
        nxt = (w.next_state >= STATES) ? STATES - 1 : w.next_state;
        r   = '0;
        if (w.op == tqla_pkg::OP_CHOOSE) begin
            if (int'(w.draw) < epsilon_q16) begin
                act = (w.rnd_action >= ACTIONS) ? ACTIONS - 1 : w.rnd_action;
                r.explored = 1'b1;
            end else begin
                act = row_best(cur_state, top);
            end
            prev_action = act;
            r.action = act[1:0];
        end else begin
            if (w.outcome == tqla_pkg::OUTCOME_FRUIT) begin
                reward = longint'(fruit_pts) * 65536;
            end else if (w.outcome == tqla_pkg::OUTCOME_CRASH) begin
                reward = longint'(crash_pts) * 65536;
            end else begin
                reward = longint'(move_pts) * 65536;
            end
            act = (prev_action >= ACTIONS) ? ACTIONS - 1 : prev_action;
            idx = cur_state * ACTIONS + act;
            void'(row_best(nxt, top));
            q      = longint'(q_table[idx]);
            target = reward + round_q16(longint'(gamma_q16) * longint'(top));
            nv     = q + round_q16(longint'(alpha_q16) * (target - q));
            if (nv > 64'sd2147483647) begin
                nv = 64'sd2147483647;
            end
            if (nv < -64'sd2147483648) begin
                nv = -64'sd2147483648;
            end
            q_table[idx] = nv[31:0];
            if (w.outcome != tqla_pkg::OUTCOME_CRASH) begin
                cur_state = nxt;
            end
            r.action    = act[1:0];
            r.new_value = nv[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_agent_step(pending_words[0]));
                void'(pending_words.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // The offered word stays on the bus until it is taken.
            end else if (pending_words.size() != 0 && !sender_pause &&
                         int'($urandom_range(99)) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_words[0].op;
                s_tdata  <= {pending_words[0].rnd_action, pending_words[0].draw,
                             pending_words[0].outcome, pending_words[0].next_state};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            hold_cycles <= 0;
        end else if (long_hold && hold_cycles < HOLD_LEN) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            if (!long_hold) begin
                hold_cycles <= 0;
            end
            m_tready <= !(int'($urandom_range(99)) < recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        agent_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word, action", m_tdata[1:0], -1);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] !== want.action) begin
                    report_mismatch("action", m_tdata[1:0], want.action);
                end
                if (m_tuser !== want.explored) begin
                    report_mismatch("explored", m_tuser, want.explored);
                end
                if (m_tdata[33:2] !== want.new_value) begin
                    report_mismatch("new_value", $signed(m_tdata[33:2]), want.new_value);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("tabular_q_learning_agent_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic write_register(logic [tqla_pkg::CFG_ADDR_W-1:0] addr,
                                  logic [tqla_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            tqla_pkg::CFG_LEARN_RATE:   alpha_q16   = int'(value);
            tqla_pkg::CFG_DISCOUNT:     gamma_q16   = int'(value);
            tqla_pkg::CFG_EXPLORE:      epsilon_q16 = int'(value);
            tqla_pkg::CFG_FRUIT_REWARD: fruit_pts   = int'($signed(value));
            tqla_pkg::CFG_CRASH_REWARD: crash_pts   = int'($signed(value));
            tqla_pkg::CFG_MOVE_REWARD:  move_pts    = int'($signed(value));
            default: ;
        endcase
    endtask

    task automatic apply_settings(int lr, int disc, int thr, int fr, int cr, int mv);
        write_register(tqla_pkg::CFG_LEARN_RATE, lr[15:0]);
        write_register(tqla_pkg::CFG_DISCOUNT, disc[15:0]);
        write_register(tqla_pkg::CFG_EXPLORE, thr[15:0]);
        write_register(tqla_pkg::CFG_FRUIT_REWARD, fr[15:0]);
        write_register(tqla_pkg::CFG_CRASH_REWARD, cr[15:0]);
        write_register(tqla_pkg::CFG_MOVE_REWARD, mv[15:0]);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function automatic agent_word_t make_word(logic op, int ns, int oc, int draw, int rnd);
        agent_word_t w;
        w.op         = op;
        w.next_state = ns[3:0];
        w.outcome    = oc[1:0];
        w.draw       = draw[15:0];
        w.rnd_action = rnd[1:0];
        return w;
    endfunction

    function automatic agent_word_t random_word(logic op);
        int e;
        case ($urandom_range(3))
            0: begin
                e = epsilon_q16 + int'($urandom_range(2)) - 1;
                if (e < 0) begin
                    e = 0;
                end
                if (e > 65535) begin
                    e = 65535;
                end
            end
            1: e = $urandom_range(1) ? 65535 : 0;
            default: e = $urandom_range(65535);
        endcase
        return make_word(op, $urandom_range(15), $urandom_range(3), e, $urandom_range(3));
    endfunction

    // Mostly choose-then-learn steps, as an agent runs, with stray words mixed in.
    task automatic queue_random_steps(int n);
        int count;
        count = 0;
        while (count < n) begin
            if ($urandom_range(9) < 7) begin
                pending_words.push_back(random_word(tqla_pkg::OP_CHOOSE));
                pending_words.push_back(random_word(tqla_pkg::OP_LEARN));
                count += 2;
            end else begin
                pending_words.push_back(random_word(1'($urandom_range(1))));
                count += 1;
            end
        end
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    initial begin
        for (int i = 0; i < STATES*ACTIONS; i++) begin
            q_table[i] = tqla_pkg::ONE_Q16;
        end
        cur_state      = 0;
        prev_action    = 0;
        alpha_q16      = int'(tqla_pkg::RST_LEARN_RATE);
        gamma_q16      = int'(tqla_pkg::RST_DISCOUNT);
        epsilon_q16    = int'(tqla_pkg::RST_EXPLORE);
        fruit_pts      = int'($signed(tqla_pkg::RST_FRUIT_REWARD));
        crash_pts      = int'($signed(tqla_pkg::RST_CRASH_REWARD));
        move_pts       = int'($signed(tqla_pkg::RST_MOVE_REWARD));
        sender_pause   = 1'b0;
        long_hold      = 1'b0;
        set_idling(0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: a learn word before any choice, exploration edges,
        // clipped random actions, every outcome code including the unused one.
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  5,  0, 0,     0));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 65535, 1));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 0,     3));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  15, 1, 0,     0));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 19660, 1));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 19661, 2));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  0,  2, 0,     0));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 65535, 0));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  15, 3, 0,     3));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 0,     0));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  0,  0, 65535, 0));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 100,   2));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  15, 2, 0,     1));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 40000, 1));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  8,  1, 0,     0));
        pending_words.push_back(make_word(tqla_pkg::OP_CHOOSE, 0,  0, 65535, 3));
        pending_words.push_back(make_word(tqla_pkg::OP_LEARN,  3,  3, 0,     2));
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: apply_settings(3277, 58982, 19661, 1000, -1000, 1);
                1: apply_settings(65535, 65535, 65535, 32767, -32768, 32767);
                2: apply_settings(0, 0, 0, -32768, 32767, -32768);
                3: apply_settings(65535, 0, 32768, 32767, -32768, 0);
                4: apply_settings($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535));
                5: apply_settings(32768, 65535, 1, -1, 1, -1);
                6: apply_settings($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535));
                7: apply_settings(65535, 65535, 0, 32767, 32767, 32767);
                default: apply_settings(65535, 65535, 0, -32768, -32768, -32768);
            endcase
            set_idling(p % 4);
            queue_random_steps(205);
            wait_drained();
        end

        // The receiver holds off while words keep coming, so the input backs up.
        apply_settings(6554, 58982, 16384, 10, -100, -1);
        set_idling(0);
        long_hold = 1'b1;
        queue_random_steps(40);
        while (hold_cycles < HOLD_LEN) begin
            @(negedge aclk);
        end
        long_hold = 1'b0;
        wait_drained();

        // The sender stops partway through until every result is back.
        set_idling(3);
        queue_random_steps(60);
        while (pending_words.size() > 30) begin
            @(negedge aclk);
        end
        sender_pause = 1'b1;
        while (s_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        sender_pause = 1'b0;
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tabular_q_learning_agent_unit_tb OK");
        end else begin
            $display("tabular_q_learning_agent_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tqla_pkg.sv
rtl/tqla_front.sv
rtl/tqla_fifo.sv
rtl/tqla_back.sv
rtl/tabular_q_learning_agent_unit.sv
sim/tabular_q_learning_agent_unit_tb.sv
